// ===== design/spg_pkg.sv =====
package spg_pkg;

    localparam logic [15:0] ONE_Q15   = 16'd32768;
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [13:0] EXP_MAX   = 14'd14336;
    localparam logic [20:0] RATE_MAX  = 21'd1677721;
    localparam logic [15:0] SPMS_MIN  = 16'd256;
    localparam logic [16:0] OFS_MAX   = 17'd65536;
    localparam int          DIV_W     = 53;
    localparam int          SQ_STEPS  = 16;

    localparam logic [1:0] CFG_EXPONENT = 2'd0;
    localparam logic [1:0] CFG_RATE     = 2'd1;
    localparam logic [1:0] CFG_FLOOR    = 2'd2;
    localparam logic [1:0] CFG_SPMS     = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHK,
        S_RCHK,
        S_OMUL,
        S_ODIV,
        S_OEND,
        S_NORM,
        S_SQ,
        S_SQN,
        S_PMUL,
        S_PEND,
        S_RT,
        S_RTN,
        S_SHIFT,
        S_MIX,
        S_CAP,
        S_LMUL,
        S_LEND,
        S_RMUL,
        S_REND,
        S_OUT
    } t_state;

    typedef logic [30:0] t_root_tab [0:15];

    function automatic longint unsigned f_isqrt(longint unsigned v);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned bitv;
        rem  = v;
        res  = 0;
        bitv = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^-(2^-k) in Q1.30, k = 0..15
    function automatic t_root_tab f_roots();
        t_root_tab       tab;
        longint unsigned r;
        r = 64'd1 << 29;
        for (int k = 0; k < 16; k++) begin
            if (k > 0) r = f_isqrt(r << 30);
            tab[k] = r[30:0];
        end
        return tab;
    endfunction

    localparam t_root_tab ROOTS = f_roots();

endpackage

// ===== design/smoothed_power_gain_stereo.sv =====
// Channel   | Dir | Fields (lsb first)
// s_axis    | in  | left_in, right_in, base_setting
// m_axis    | out | left_out, right_out
// cfg       | in  | index 0 exponent, 1 rate, 2 floor, 3 samples per ms
// One transfer runs on one shared 32x32 multiplier: 14 fixed steps, 16 squarings and
// 16 root products (each a multiply and a normalise state; these and three steps are
// skipped for a zero base), a restoring division while ramping, two on a re-anchor.
// Synchronous active-low reset restores register defaults and clears the ramp.
// s_axis_tready is high only while idle; S_OUT holds while an earlier result waits.
module smoothed_power_gain_stereo import spg_pkg::*; #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // left_in, right_in, base_setting
    input  logic [((2*SAMPLE_WIDTH+16+7)/8)*8-1:0]       s_axis_tdata,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // left_out, right_out
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]          m_axis_tdata,
    input  logic                                          i_cfg_we,
    input  logic [1:0]                                    i_cfg_addr,
    input  logic [20:0]                                   i_cfg_data
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int OUT_W = ((2*SAMPLE_WIDTH+7)/8)*8;

    t_state r_state, n_state;

    logic [13:0] r_exp;
    logic [20:0] r_rate;
    logic [15:0] r_floor;
    logic [15:0] r_spms;

    logic signed [SW-1:0] r_left, r_right, r_lo, r_ro;
    logic [15:0]       r_req, r_start, r_target, r_cur, r_frac, r_fp;
    logic              r_ramping, r_anchor, r_m_valid;
    logic [31:0]       r_since;
    logic [63:0]       r_prod;
    logic [16:0]       r_rem;
    logic [DIV_W-1:0]  r_quo;
    logic [5:0]        r_cnt;
    logic [30:0]       r_y, r_acc, r_g, r_mult;
    logic [3:0]        r_lz;
    logic [5:0]        r_ip;
    logic [OUT_W-1:0]  r_m_data;

    logic [13:0] exp_c;
    logic [20:0] rate_c;
    logic [15:0] fl_c, spms_c, req_c;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    assign exp_c  = (r_exp > EXP_MAX) ? EXP_MAX : r_exp;
    assign rate_c = (r_rate > RATE_MAX) ? RATE_MAX : r_rate;
    assign fl_c   = (r_floor > ONE_Q15) ? ONE_Q15 : r_floor;
    assign spms_c = (r_spms < SPMS_MIN) ? SPMS_MIN : r_spms;
    assign req_c  = (s_axis_tdata[2*SW+15:2*SW] > ONE_Q15) ? ONE_Q15
                                                           : s_axis_tdata[2*SW+15:2*SW];

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // divider step
    logic [17:0] rem_sh, div18;
    logic        qbit;
    assign div18  = {1'b0, spms_c, 1'b0};
    assign rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign qbit   = (rem_sh >= div18);

    // ramp offset arithmetic
    logic [16:0]        ofs;
    logic signed [18:0] st_s, tg_s, lo_s, hi_s, np_s, cur_s;
    logic               ramp_nx;
    assign ofs  = (r_quo > DIV_W'(OFS_MAX)) ? OFS_MAX : r_quo[16:0];
    assign st_s = signed'({3'b0, r_start});
    assign tg_s = signed'({3'b0, r_target});
    assign lo_s = st_s - signed'({2'b0, ofs});
    assign hi_s = st_s + signed'({2'b0, ofs});

    always_comb begin
        if (tg_s < st_s) begin
            np_s    = (lo_s < tg_s) ? tg_s : lo_s;
            ramp_nx = (lo_s > tg_s);
            cur_s   = lo_s;
        end else begin
            np_s    = (hi_s > tg_s) ? tg_s : hi_s;
            ramp_nx = (hi_s < tg_s);
            cur_s   = hi_s;
        end
        if (!ramp_nx) cur_s = tg_s;
    end

    // leading zero count of the base
    logic [3:0] lz;
    always_comb begin
        lz = 4'd15;
        for (int i = 0; i < 16; i++) begin
            if (r_cur[i]) lz = 4'(15 - i);
        end
    end

    logic [31:0] sq_t;
    logic [19:0] n_log;
    logic [31:0] mix_m;
    assign sq_t  = r_prod[61:30];
    assign n_log = {r_lz, 16'b0} - {4'b0, r_frac};
    assign mix_m = {1'b0, fl_c, 15'b0} + 32'(r_prod[46:15]);

    logic          fp_bit;
    assign fp_bit = r_fp[4'(15 - r_cnt[3:0])];

    logic [SW-1:0] mag_l, mag_r;
    assign mag_l = r_left[SW-1]  ? SW'(-r_left)  : SW'(r_left);
    assign mag_r = r_right[SW-1] ? SW'(-r_right) : SW'(r_right);

    logic [SW-1:0] scl;
    assign scl = r_prod[SW+29:30];

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_OMUL: begin
                mul_a = r_since;
                mul_b = 32'(r_anchor ? r_rate : rate_c);
            end
            S_SQ: begin
                mul_a = 32'(r_y);
                mul_b = 32'(r_y);
            end
            S_PMUL: begin
                mul_a = 32'(n_log);
                mul_b = 32'(exp_c);
            end
            S_RT: begin
                mul_a = 32'(r_acc);
                mul_b = 32'(ROOTS[r_cnt[3:0]]);
            end
            S_MIX: begin
                mul_a = 32'(ONE_Q15 - fl_c);
                mul_b = 32'(r_g);
            end
            S_LMUL: begin
                mul_a = 32'(mag_l);
                mul_b = 32'(r_mult);
            end
            S_RMUL: begin
                mul_a = 32'(mag_r);
                mul_b = 32'(r_mult);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (s_axis_tvalid) n_state = S_CHK;
            S_CHK: begin
                if (r_req == r_target)                   n_state = S_RCHK;
                else if (r_ramping && (r_rate != '0))    n_state = S_OMUL;
                else                                     n_state = S_RCHK;
            end
            S_RCHK:  n_state = r_ramping ? S_OMUL : S_NORM;
            S_OMUL:  n_state = S_ODIV;
            S_ODIV:  if (r_cnt == 6'(DIV_W - 1)) n_state = S_OEND;
            S_OEND:  n_state = r_anchor ? S_RCHK : S_NORM;
            S_NORM:  n_state = (r_cur == '0) ? S_MIX : S_SQ;
            S_SQ:    n_state = S_SQN;
            S_SQN:   n_state = (r_cnt == 6'(SQ_STEPS - 1)) ? S_PMUL : S_SQ;
            S_PMUL:  n_state = S_PEND;
            S_PEND:  n_state = S_RT;
            S_RT:    n_state = S_RTN;
            S_RTN:   n_state = (r_cnt == 6'd15) ? S_SHIFT : S_RT;
            S_SHIFT: n_state = S_MIX;
            S_MIX:   n_state = S_CAP;
            S_CAP:   n_state = S_LMUL;
            S_LMUL:  n_state = S_LEND;
            S_LEND:  n_state = S_RMUL;
            S_RMUL:  n_state = S_REND;
            S_REND:  n_state = S_OUT;
            S_OUT:   if (!r_m_valid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_exp     <= 14'd4096;
            r_rate    <= '0;
            r_floor   <= '0;
            r_spms    <= 16'd12288;
            r_start   <= '0;
            r_target  <= '0;
            r_ramping <= 1'b0;
            r_since   <= '0;
            r_anchor  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_EXPONENT: r_exp   <= i_cfg_data[13:0];
                    CFG_RATE:     r_rate  <= i_cfg_data;
                    CFG_FLOOR:    r_floor <= i_cfg_data[15:0];
                    CFG_SPMS:     r_spms  <= i_cfg_data[15:0];
                    default:      r_exp   <= r_exp;
                endcase
            end
            if (r_m_valid && m_axis_tready && (r_state != S_OUT)) r_m_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_left  <= s_axis_tdata[SW-1:0];
                    r_right <= s_axis_tdata[2*SW-1:SW];
                    r_req   <= req_c;
                end
                S_CHK: begin
                    r_anchor <= (r_req != r_target) && r_ramping && (r_rate != '0);
                    if ((r_req != r_target) && !(r_ramping && (r_rate != '0))) begin
                        r_start   <= r_target;
                        r_ramping <= (r_rate != '0);
                        r_since   <= '0;
                        r_target  <= r_req;
                    end
                end
                S_RCHK: begin
                    r_cur <= r_target;
                end
                S_OMUL: begin
                    r_quo <= mul_p[DIV_W-1:0];
                    r_rem <= '0;
                    r_cnt <= '0;
                end
                S_ODIV: begin
                    r_rem <= qbit ? 17'(rem_sh - div18) : rem_sh[16:0];
                    r_quo <= {r_quo[DIV_W-2:0], qbit};
                    r_cnt <= r_cnt + 6'd1;
                end
                S_OEND: begin
                    if (r_anchor) begin
                        r_anchor  <= 1'b0;
                        r_start   <= np_s[15:0];
                        r_ramping <= 1'b1;
                        r_since   <= '0;
                        r_target  <= r_req;
                    end else begin
                        r_ramping <= ramp_nx;
                        r_cur     <= cur_s[15:0];
                    end
                end
                S_NORM: begin
                    r_g    <= (exp_c == '0) ? ONE_Q30 : '0;
                    r_y    <= {(r_cur << lz), 15'b0};
                    r_lz   <= lz;
                    r_frac <= '0;
                    r_cnt  <= '0;
                end
                S_SQ: r_prod <= mul_p;
                S_SQN: begin
                    if (sq_t[31]) begin
                        r_y    <= sq_t[31:1];
                        r_frac <= {r_frac[14:0], 1'b1};
                    end else begin
                        r_y    <= sq_t[30:0];
                        r_frac <= {r_frac[14:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 6'd1;
                end
                S_PMUL: r_prod <= mul_p;
                S_PEND: begin
                    r_ip  <= r_prod[33:28];
                    r_fp  <= r_prod[27:12];
                    r_acc <= ONE_Q30;
                    r_cnt <= '0;
                end
                S_RT: r_prod <= mul_p;
                S_RTN: begin
                    if (fp_bit) r_acc <= r_prod[60:30];
                    r_cnt <= r_cnt + 6'd1;
                end
                S_SHIFT: r_g <= (r_ip > 6'd30) ? '0 : (r_acc >> r_ip);
                S_MIX:   r_prod <= mul_p;
                S_CAP:   r_mult <= (mix_m > 32'(ONE_Q30)) ? ONE_Q30 : mix_m[30:0];
                S_LMUL:  r_prod <= mul_p;
                S_LEND:  r_lo <= r_left[SW-1] ? -signed'(scl) : signed'(scl);
                S_RMUL:  r_prod <= mul_p;
                S_REND: begin
                    r_ro <= r_right[SW-1] ? -signed'(scl) : signed'(scl);
                    if (r_since != '1) r_since <= r_since + 32'd1;
                end
                S_OUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= OUT_W'({r_ro, r_lo});
                    end
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_target <= ONE_Q15) else $error("ramp target out of range");

    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM) |-> (r_cur <= ONE_Q15)) else $error("base out of range");

    a_mult_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LMUL) |-> (r_mult <= ONE_Q30)) else $error("multiplier above one");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_m_valid || m_axis_tready)) |=> r_m_valid)
        else $error("result not presented");

endmodule
